### rtl/fac_pkg.sv
// shared types, codes and constants of the frustum box culling block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fac_pkg;

    // fixed point formats
    localparam int COORD_FRAC_BITS  = 16;
    localparam int NORMAL_FRAC_BITS = 30;

    // store sizes
    localparam int PLANE_COUNT  = 6;
    localparam int NORMAL_COUNT = 18;
    localparam int MATRIX_SIZE  = 16;

    // item kinds carried on tuser
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_REBUILD = 2'd1;
    localparam logic [1:0] OP_TEST    = 2'd2;

    // rejecting plane code when no plane rejects
    localparam logic [2:0] NO_PLANE = 3'd6;

    typedef logic signed [31:0] fac_word_t;

    // item handed from the entry stage to the box pipeline
    typedef struct packed {
        logic [1:0]      op;
        logic            degen;
        fac_word_t [2:0] lo;
        fac_word_t [2:0] hi;
    } fac_item_t;

    // control towards the plane builder
    typedef struct packed {
        logic start;
        logic ack;
    } fac_bld_ctl_t;

    // status from the plane builder
    typedef struct packed {
        logic busy;
        logic done;
        logic any;
    } fac_bld_stat_t;

    // planes 0, 3 and 4 add the row to row 3, the others subtract it
    function automatic logic plane_adds(input logic [2:0] k);
        logic r;
        case (k)
            3'd0, 3'd3, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/fac_plane_builder.sv
// matrix store, plane stores and the sequential plane extraction engine
// depends on fac_pkg
`timescale 1ns / 1ps

module fac_plane_builder
    import fac_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [3:0]    wr_index,
    input  fac_word_t     wr_value,
    input  fac_bld_ctl_t  ctl,
    output fac_bld_stat_t stat,
    output fac_word_t     normals [NORMAL_COUNT],
    output fac_word_t     offsets [PLANE_COUNT],
    output logic [PLANE_COUNT-1:0] marks
);

    typedef enum logic [3:0] {
        B_IDLE, B_LOAD, B_SQ_LD, B_SQ_RUN, B_RT_LD, B_RT_RUN,
        B_DIV_LD, B_DIV_RUN, B_NEXT, B_DONE
    } bstate_t;

    bstate_t state_reg;

    fac_word_t matrix_reg  [MATRIX_SIZE];
    fac_word_t normals_reg [NORMAL_COUNT];
    fac_word_t offsets_reg [PLANE_COUNT];
    logic [PLANE_COUNT-1:0] marks_reg;

    logic [2:0]       plane_reg;
    logic [1:0]       cj_reg;
    logic [5:0]       step_reg;
    logic [3:0][32:0] comp_reg;
    logic [65:0]      sum_reg;
    logic [65:0]      mcand_reg;
    logic [32:0]      mplier_reg;
    logic [67:0]      rad_reg;
    logic [36:0]      rem_reg;
    logic [33:0]      root_reg;
    logic [63:0]      dvd_reg;
    logic [63:0]      quo_reg;
    logic             neg_reg;
    logic             any_reg;

    logic [3:0]  load_addr;
    logic [32:0] load_ext;
    logic [32:0] load_val;
    logic [32:0] mag0;
    logic [36:0] rt_sh;
    logic [36:0] rt_trial;
    logic        rt_take;
    logic [33:0] root_nx;
    logic [34:0] d_sh;
    logic        d_take;
    logic [63:0] qfin;
    logic [31:0] nval;
    logic [31:0] oval;
    logic [4:0]  nidx;

    // element fetch and component build
    always_comb
    begin
        load_addr = step_reg[2] ? {plane_reg[2:1], step_reg[1:0]} : {2'b11, step_reg[1:0]};
        load_ext  = {matrix_reg[load_addr][31], matrix_reg[load_addr]};
        if (!step_reg[2])
            load_val = load_ext;
        else if (plane_adds(plane_reg))
            load_val = comp_reg[0] + load_ext;
        else
            load_val = comp_reg[0] - load_ext;
        mag0 = comp_reg[0][32] ? (33'd0 - comp_reg[0]) : comp_reg[0];
    end

    // one root digit per cycle
    always_comb
    begin
        rt_sh    = {rem_reg[34:0], rad_reg[67:66]};
        rt_trial = {1'b0, root_reg, 2'b01};
        rt_take  = (rt_sh >= rt_trial);
        root_nx  = {root_reg[32:0], rt_take};
    end

    // one quotient bit per cycle, then sign and saturation
    always_comb
    begin
        d_sh   = {rem_reg[33:0], dvd_reg[63]};
        d_take = (d_sh >= {1'b0, root_reg});
        qfin   = {quo_reg[62:0], d_take};
        nval   = neg_reg ? (32'd0 - qfin[31:0]) : qfin[31:0];
        if (neg_reg)
            oval = (qfin > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - qfin[31:0]);
        else
            oval = (qfin > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qfin[31:0];
        nidx = 5'(plane_reg) * 5'd3 + 5'(cj_reg);
    end

    // sequencer, stores and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            plane_reg  <= '0;
            cj_reg     <= '0;
            step_reg   <= '0;
            comp_reg   <= '0;
            sum_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            rad_reg    <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
            dvd_reg    <= '0;
            quo_reg    <= '0;
            neg_reg    <= 1'b0;
            any_reg    <= 1'b0;
            marks_reg  <= '0;
            for (int i = 0; i < MATRIX_SIZE; i++)
                matrix_reg[i] <= '0;
            for (int i = 0; i < NORMAL_COUNT; i++)
                normals_reg[i] <= '0;
            for (int i = 0; i < PLANE_COUNT; i++)
                offsets_reg[i] <= '0;
        end
        else
        begin
            if (wr_en)
                matrix_reg[wr_index] <= wr_value;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (ctl.start)
                    begin
                        state_reg <= B_LOAD;
                        plane_reg <= '0;
                        step_reg  <= '0;
                        any_reg   <= 1'b0;
                    end
                end
                B_LOAD:
                begin
                    comp_reg <= {load_val, comp_reg[3:1]};
                    sum_reg  <= '0;
                    if (step_reg == 6'd7)
                    begin
                        state_reg <= B_SQ_LD;
                        cj_reg    <= '0;
                    end
                    step_reg <= step_reg + 6'd1;
                end
                B_SQ_LD:
                begin
                    mcand_reg  <= 66'(mag0);
                    mplier_reg <= mag0;
                    comp_reg   <= {comp_reg[0], comp_reg[3:1]};
                    step_reg   <= '0;
                    state_reg  <= B_SQ_RUN;
                end
                B_SQ_RUN:
                begin
                    if (mplier_reg[0])
                        sum_reg <= sum_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[64:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[32:1]};
                    step_reg   <= step_reg + 6'd1;
                    if (step_reg == 6'd32)
                    begin
                        if (cj_reg == 2'd2)
                            state_reg <= B_RT_LD;
                        else
                        begin
                            cj_reg    <= cj_reg + 2'd1;
                            state_reg <= B_SQ_LD;
                        end
                    end
                end
                B_RT_LD:
                begin
                    comp_reg  <= {comp_reg[0], comp_reg[3:1]};
                    rad_reg   <= {2'b00, sum_reg};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= B_RT_RUN;
                end
                B_RT_RUN:
                begin
                    rem_reg  <= rt_take ? (rt_sh - rt_trial) : rt_sh;
                    root_reg <= root_nx;
                    rad_reg  <= {rad_reg[65:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd33)
                    begin
                        cj_reg <= '0;
                        if (root_nx == '0)
                        begin
                            // zero length: cleared plane that never rejects
                            for (int j = 0; j < 3; j++)
                                normals_reg[5'(plane_reg) * 5'd3 + 5'(j)] <= '0;
                            offsets_reg[plane_reg] <= '0;
                            marks_reg[plane_reg]   <= 1'b1;
                            any_reg                <= 1'b1;
                            state_reg              <= B_NEXT;
                        end
                        else
                            state_reg <= B_DIV_LD;
                    end
                end
                B_DIV_LD:
                begin
                    if (cj_reg == 2'd3)
                        dvd_reg <= 64'(mag0) << COORD_FRAC_BITS;
                    else
                        dvd_reg <= 64'(mag0) << NORMAL_FRAC_BITS;
                    neg_reg   <= comp_reg[0][32];
                    comp_reg  <= {comp_reg[0], comp_reg[3:1]};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= B_DIV_RUN;
                end
                B_DIV_RUN:
                begin
                    rem_reg  <= 37'(d_take ? (d_sh - {1'b0, root_reg}) : d_sh);
                    quo_reg  <= qfin;
                    dvd_reg  <= {dvd_reg[62:0], 1'b0};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd63)
                    begin
                        if (cj_reg == 2'd3)
                        begin
                            offsets_reg[plane_reg] <= oval;
                            marks_reg[plane_reg]   <= 1'b0;
                            state_reg              <= B_NEXT;
                        end
                        else
                        begin
                            normals_reg[nidx] <= nval;
                            cj_reg            <= cj_reg + 2'd1;
                            state_reg         <= B_DIV_LD;
                        end
                    end
                end
                B_NEXT:
                begin
                    step_reg <= '0;
                    if (plane_reg == 3'(PLANE_COUNT - 1))
                        state_reg <= B_DONE;
                    else
                    begin
                        plane_reg <= plane_reg + 3'd1;
                        state_reg <= B_LOAD;
                    end
                end
                B_DONE:
                begin
                    if (ctl.ack)
                        state_reg <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    // status and store outputs
    assign stat.busy = (state_reg != B_IDLE) && (state_reg != B_DONE);
    assign stat.done = (state_reg == B_DONE);
    assign stat.any  = any_reg;
    assign normals   = normals_reg;
    assign offsets   = offsets_reg;
    assign marks     = marks_reg;

endmodule

### rtl/fac_box_pipe.sv
// three stage box test pipeline: corner products, plane sums, first reject
// depends on fac_pkg; plane values come from fac_plane_builder
`timescale 1ns / 1ps

module fac_box_pipe
    import fac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fac_item_t in_item,
    input  fac_word_t normals [NORMAL_COUNT],
    input  fac_word_t offsets [PLANE_COUNT],
    input  logic [PLANE_COUNT-1:0] marks,
    output logic      empty,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] out_data
);

    logic                   s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [1:0]             s2_op_reg, s3_op_reg;
    logic                   s2_degen_reg, s3_degen_reg;
    logic signed [63:0]     s2_prod_reg [NORMAL_COUNT];
    logic signed [63:0]     prod_next   [NORMAL_COUNT];
    logic [PLANE_COUNT-1:0] s3_neg_reg, neg_next;
    logic [7:0]             s4_data_reg, data_next;
    logic                   s2_ready, s3_ready, s4_ready;
    logic [63:0]            acc;
    logic [2:0]             rej;

    // stall chain
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;
    assign empty    = !s2_valid_reg && !s3_valid_reg;

    // farthest corner along each normal, one product per component
    always_comb
    begin
        for (int k = 0; k < PLANE_COUNT; k++)
            for (int j = 0; j < 3; j++)
                prod_next[k*3+j] = normals[k*3+j] *
                    (normals[k*3+j][31] ? in_item.lo[j] : in_item.hi[j]);
    end

    // plane sums, wrapped to 64 bits, sign taken
    always_comb
    begin
        acc = '0;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            acc = (64'(offsets[k]) << NORMAL_FRAC_BITS) + 64'(s2_prod_reg[k*3])
                + 64'(s2_prod_reg[k*3+1]) + 64'(s2_prod_reg[k*3+2]);
            neg_next[k] = acc[63] && !marks[k];
        end
    end

    // first rejecting plane and result packing
    always_comb
    begin
        rej = NO_PLANE;
        for (int k = PLANE_COUNT - 1; k >= 0; k--)
            if (s3_neg_reg[k])
                rej = 3'(k);
        if (s3_op_reg != OP_TEST)
            rej = NO_PLANE;
        data_next = {3'b000, (s3_op_reg == OP_REBUILD) && s3_degen_reg, rej,
                     (s3_op_reg == OP_TEST) && (rej == NO_PLANE)};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= in_valid;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s2_ready && in_valid)
        begin
            s2_op_reg    <= in_item.op;
            s2_degen_reg <= in_item.degen;
            s2_prod_reg  <= prod_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_degen_reg <= s2_degen_reg;
            s3_neg_reg   <= neg_next;
        end
        if (s4_ready && s3_valid_reg)
            s4_data_reg <= data_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

endmodule

### rtl/frustum_aabb_cull_core.sv
// top level of the frustum box culling block: entry stage and wiring
// depends on fac_pkg, fac_plane_builder and fac_box_pipe
//
// usage
//   items arrive on the s_axis channel; tuser carries the kind: matrix
//   element write, plane rebuild or box test. every item gives one result
//   item on the m_axis channel, in order.
//   box tests and element writes stream at one item per clock while
//   m_axis_tready stays high; a result passes the entry, product,
//   plane sum and output registers.
//   a rebuild holds in the entry stage until the items ahead of it have
//   left the product and sum stages, then the plane builder runs its
//   shift-add squarer, digit root and restoring divider, plane by
//   plane for all six; nothing new is accepted meanwhile.
//   reset clears the matrix and all planes, so every box is visible until
//   the first rebuild; it also empties the pipeline.
//   when m_axis_tready is low the output register holds and the stages
//   behind it fill one by one, then s_axis_tready drops; nothing is lost.
`timescale 1ns / 1ps

module frustum_aabb_cull_core
    import fac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // elem_index, elem_value, min_x, min_y, min_z, max_x, max_y, max_z, zero pad
    input  logic [231:0] s_axis_tdata,
    // op
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // visible, rejecting_plane, degenerate, zero pad
    output logic [7:0]   m_axis_tdata
);

    logic            s1_valid_reg;
    logic [1:0]      s1_op_reg;
    fac_word_t [2:0] s1_lo_reg;
    fac_word_t [2:0] s1_hi_reg;
    logic            s1_go;
    logic            accept;
    logic            pipe_in_valid, pipe_in_ready, pipe_empty;
    fac_item_t       pipe_item;
    fac_bld_ctl_t    bld_ctl;
    fac_bld_stat_t   bld_stat;
    fac_word_t       normals [NORMAL_COUNT];
    fac_word_t       offsets [PLANE_COUNT];
    logic [PLANE_COUNT-1:0] marks;

    // entry stage handshake; a rebuild waits for the builder
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pipe_in_valid = s1_valid_reg && ((s1_op_reg != OP_REBUILD) || bld_stat.done);
    assign s1_go         = pipe_in_valid && pipe_in_ready;
    assign s_axis_tready = !s1_valid_reg || s1_go;

    assign bld_ctl.start = s1_valid_reg && (s1_op_reg == OP_REBUILD) && pipe_empty;
    assign bld_ctl.ack   = s1_go;

    // item towards the box pipeline
    assign pipe_item.op    = s1_op_reg;
    assign pipe_item.degen = (s1_op_reg == OP_REBUILD) && bld_stat.any;
    assign pipe_item.lo    = s1_lo_reg;
    assign pipe_item.hi    = s1_hi_reg;

    // entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= s_axis_tuser;
            s1_lo_reg[0] <= s_axis_tdata[67:36];
            s1_lo_reg[1] <= s_axis_tdata[99:68];
            s1_lo_reg[2] <= s_axis_tdata[131:100];
            s1_hi_reg[0] <= s_axis_tdata[163:132];
            s1_hi_reg[1] <= s_axis_tdata[195:164];
            s1_hi_reg[2] <= s_axis_tdata[227:196];
        end
    end

    fac_plane_builder u_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && (s_axis_tuser == OP_WRITE)),
        .wr_index (s_axis_tdata[3:0]),
        .wr_value (s_axis_tdata[35:4]),
        .ctl      (bld_ctl),
        .stat     (bld_stat),
        .normals  (normals),
        .offsets  (offsets),
        .marks    (marks)
    );

    fac_box_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_in_valid),
        .in_ready  (pipe_in_ready),
        .in_item   (pipe_item),
        .normals   (normals),
        .offsets   (offsets),
        .marks     (marks),
        .empty     (pipe_empty),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // planes change only while no test reads them
    a_build_drained: assert property (@(posedge clk) disable iff (!rst_n)
        bld_stat.busy |-> pipe_empty)
        else $error("plane builder running with tests in flight");

    // a rebuild leaves the entry stage only once the planes are ready
    a_rebuild_done: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_op_reg == OP_REBUILD)) |-> bld_stat.done)
        else $error("rebuild item passed before planes were built");

    // no item taken while the builder works
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bld_stat.busy |-> !s_axis_tready)
        else $error("item accepted during plane rebuild");

    // a visible box names no rejecting plane
    a_visible_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == NO_PLANE))
        else $error("visible result with a rejecting plane");

endmodule
